FILE: hdl/lav_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lav_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int IN_W          = 32;
    localparam int D_W           = 33;
    localparam int COL_W         = 34;
    localparam int S_TDATA_W     = 6 * IN_W;
    localparam int M_TDATA_W     = 4 * COL_W;
    localparam int M_TUSER_W     = 3;
    localparam int Q_DEPTH       = 2;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);

    typedef struct packed {
        logic signed [IN_W-1:0] px;
        logic signed [IN_W-1:0] py;
        logic signed [IN_W-1:0] pz;
        logic signed [D_W-1:0]  dx;
        logic signed [D_W-1:0]  dy;
        logic signed [D_W-1:0]  dz;
        logic                   dzero;
    } lav_item_t;

endpackage

`default_nettype wire

FILE: hdl/lav_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lav_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [lav_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               f_valid,
    input  wire logic                          f_ready,
    output lav_pkg::lav_item_t                 f_item
);
    import lav_pkg::*;

    logic      fv_reg, fv_next;
    lav_item_t item_reg, item_next;
    logic signed [IN_W-1:0] px, py, pz, tx, ty, tz;
    logic      accept;

    assign px = $signed(s_tdata[31:0]);
    assign py = $signed(s_tdata[63:32]);
    assign pz = $signed(s_tdata[95:64]);
    assign tx = $signed(s_tdata[127:96]);
    assign ty = $signed(s_tdata[159:128]);
    assign tz = $signed(s_tdata[191:160]);

    assign s_tready = !fv_reg || f_ready;
    assign accept   = s_tvalid && s_tready;
    assign f_valid  = fv_reg;
    assign f_item   = item_reg;

    always_comb
    begin
        item_next = item_reg;
        fv_next   = fv_reg && !f_ready;
        if (accept)
        begin
            item_next.px    = px;
            item_next.py    = py;
            item_next.pz    = pz;
            item_next.dx    = D_W'(tx) - D_W'(px);
            item_next.dy    = D_W'(ty) - D_W'(py);
            item_next.dz    = D_W'(tz) - D_W'(pz);
            // eye on target: no z axis
            item_next.dzero = (tx == px) && (ty == py) && (tz == pz);
            fv_next         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

FILE: hdl/lav_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module lav_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire lav_pkg::lav_item_t in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output lav_pkg::lav_item_t      out_item
);
    import lav_pkg::*;

    lav_item_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]     wr_reg, wr_next, rd_reg, rd_next;
    logic [Q_PTR_W:0]       cnt_reg, cnt_next;
    logic                   push, pop;

    assign in_ready  = cnt_reg != (Q_PTR_W+1)'(Q_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_item  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/lav_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lav_back #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  wire lav_pkg::lav_item_t            q_item,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [lav_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [lav_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                               m_tlast
);
    import lav_pkg::*;

    localparam int VW  = FRAC_BITS + 3;
    localparam int QW  = FRAC_BITS + 2;
    localparam int NW  = 31 + QW;
    localparam int CW  = 6;
    localparam int AW  = 67;

    localparam logic [4:0] T_SQ_END  = 5'd2;
    localparam logic [4:0] T_Y_FIRST = 5'd3;
    localparam logic [4:0] T_Y0      = 5'd4;
    localparam logic [4:0] T_Y1      = 5'd6;
    localparam logic [4:0] T_Y2      = 5'd8;
    localparam logic [4:0] T_D0      = 5'd11;
    localparam logic [4:0] T_D1      = 5'd14;
    localparam logic [4:0] T_D2      = 5'd17;

    localparam logic [COL_W-1:0] SAT_MAX = {1'b0, {(COL_W-1){1'b1}}};
    localparam logic [COL_W-1:0] SAT_MIN = {1'b1, {(COL_W-1){1'b0}}};
    localparam logic [COL_W-1:0] ONE     = COL_W'(1) << FRAC_BITS;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCALE = 7'b0000010,
        S_MAC   = 7'b0000100,
        S_SQRT  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_SPARE = 7'b1000000
    } state_t;

    function automatic logic [33:0] mag34(input logic signed [33:0] v);
        mag34 = v[33] ? 34'(-v) : 34'(v);
    endfunction

    state_t state_reg, state_next;
    lav_item_t item_reg, item_next;
    logic pass_reg, pass_next, deg_reg, deg_next;
    logic signed [33:0] nv_reg [3];
    logic signed [33:0] nv_next [3];
    logic [33:0] m_reg [3];
    logic [33:0] m_next [3];
    logic signed [VW-1:0] z_reg [3];
    logic signed [VW-1:0] z_next [3];
    logic signed [VW-1:0] x_reg [3];
    logic signed [VW-1:0] x_next [3];
    logic signed [VW-1:0] y_reg [3];
    logic signed [VW-1:0] y_next [3];
    logic [COL_W-1:0] t_reg [3];
    logic [COL_W-1:0] t_next [3];
    logic [63:0] sx_reg, sx_next, sr_reg, sr_next, sb_reg, sb_next;
    logic [32:0] len_reg, len_next;
    logic [33:0] rem_reg, rem_next;
    logic [QW-1:0] lo_reg, lo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0] comp_reg, comp_next, row_reg, row_next;
    logic [4:0] term_reg, term_next;
    logic ph_reg, ph_next;
    logic signed [65:0] prod_reg, prod_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic mv_reg, mv_next, ol_reg, ol_next;
    logic [M_TDATA_W-1:0] od_reg, od_next;
    logic [M_TUSER_W-1:0] ou_reg, ou_next;

    logic signed [32:0] op_a, op_b;
    logic op_neg, op_fin;
    logic [33:0] big;
    logic signed [AW-1:0] acc_sum;
    logic [AW-1:0] amag, rnd;
    logic signed [VW-1:0] rnd_v, yv;
    logic [COL_W-1:0] tv;
    logic [63:0] rb;
    logic [NW-1:0] dvd;
    logic [34:0] trial;
    logic [33:0] dvs;
    logic ge;
    logic signed [VW-1:0] qs, uv;
    logic [COL_W-1:0] c0, c1, c2, c3;

    assign m_tvalid = mv_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = ou_reg;
    assign m_tlast  = ol_reg;

    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        op_neg = 1'b0;
        op_fin = 1'b0;
        case (term_reg)
            5'd0:  begin op_a = $signed({2'b00, m_reg[0][30:0]}); op_b = op_a; end
            5'd1:  begin op_a = $signed({2'b00, m_reg[1][30:0]}); op_b = op_a; end
            5'd2:
            begin
                op_a = $signed({2'b00, m_reg[2][30:0]});
                op_b = op_a;
                op_fin = 1'b1;
            end
            5'd3:  begin op_a = 33'(z_reg[1]); op_b = 33'(x_reg[2]); end
            5'd4:
            begin
                op_a = 33'(z_reg[2]); op_b = 33'(x_reg[1]); op_neg = 1'b1; op_fin = 1'b1;
            end
            5'd5:  begin op_a = 33'(z_reg[2]); op_b = 33'(x_reg[0]); end
            5'd6:
            begin
                op_a = 33'(z_reg[0]); op_b = 33'(x_reg[2]); op_neg = 1'b1; op_fin = 1'b1;
            end
            5'd7:  begin op_a = 33'(z_reg[0]); op_b = 33'(x_reg[1]); end
            5'd8:
            begin
                op_a = 33'(z_reg[1]); op_b = 33'(x_reg[0]); op_neg = 1'b1; op_fin = 1'b1;
            end
            5'd9:  begin op_a = 33'(x_reg[0]); op_b = 33'(item_reg.px); end
            5'd10: begin op_a = 33'(x_reg[1]); op_b = 33'(item_reg.py); end
            5'd11: begin op_a = 33'(x_reg[2]); op_b = 33'(item_reg.pz); op_fin = 1'b1; end
            5'd12: begin op_a = 33'(y_reg[0]); op_b = 33'(item_reg.px); end
            5'd13: begin op_a = 33'(y_reg[1]); op_b = 33'(item_reg.py); end
            5'd14: begin op_a = 33'(y_reg[2]); op_b = 33'(item_reg.pz); op_fin = 1'b1; end
            5'd15: begin op_a = 33'(z_reg[0]); op_b = 33'(item_reg.px); end
            5'd16: begin op_a = 33'(z_reg[1]); op_b = 33'(item_reg.py); end
            5'd17: begin op_a = 33'(z_reg[2]); op_b = 33'(item_reg.pz); op_fin = 1'b1; end
            default: ;
        endcase
    end

    // accumulate, then round half away from zero
    always_comb
    begin
        acc_sum = acc_reg + (op_neg ? -AW'(prod_reg) : AW'(prod_reg));
        amag    = acc_sum[AW-1] ? AW'(-acc_sum) : AW'(acc_sum);
        rnd     = (amag + (AW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        rnd_v   = $signed(rnd[VW-1:0]);
        yv      = acc_sum[AW-1] ? -rnd_v : rnd_v;
        if (acc_sum[AW-1])
        begin
            tv = (rnd > AW'(SAT_MAX)) ? SAT_MAX : rnd[COL_W-1:0];
        end
        else
        begin
            tv = (rnd > AW'(SAT_MIN)) ? SAT_MIN : COL_W'(-rnd[COL_W-1:0]);
        end
    end

    always_comb
    begin
        big = m_reg[0];
        if (m_reg[1] > big)
        begin
            big = m_reg[1];
        end
        if (m_reg[2] > big)
        begin
            big = m_reg[2];
        end
    end

    always_comb
    begin
        rb    = sr_reg + sb_reg;
        dvd   = NW'({m_reg[comp_reg][30:0], {(FRAC_BITS+1){1'b0}}}) + NW'(len_reg);
        dvs   = {len_reg, 1'b0};
        trial = {rem_reg, lo_reg[QW-1]};
        ge    = trial >= 35'(dvs);
        qs    = $signed({1'b0, lo_reg[QW-2:0], ge});
        uv    = nv_reg[comp_reg][33] ? -qs : qs;
    end

    always_comb
    begin
        c0 = '0;
        c1 = '0;
        c2 = '0;
        c3 = '0;
        if (!deg_reg)
        begin
            if (row_reg != 2'd3)
            begin
                c0 = COL_W'(x_reg[row_reg]);
                c1 = COL_W'(y_reg[row_reg]);
                c2 = COL_W'(z_reg[row_reg]);
            end
            else
            begin
                c0 = t_reg[0];
                c1 = t_reg[1];
                c2 = t_reg[2];
                c3 = ONE;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        pass_next  = pass_reg;
        deg_next   = deg_reg;
        nv_next    = nv_reg;
        m_next     = m_reg;
        z_next     = z_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        t_next     = t_reg;
        sx_next    = sx_reg;
        sr_next    = sr_reg;
        sb_next    = sb_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        lo_next    = lo_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        row_next   = row_reg;
        term_next  = term_reg;
        ph_next    = ph_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        mv_next    = mv_reg && !m_tready;
        od_next    = od_reg;
        ou_next    = ou_reg;
        ol_next    = ol_reg;
        q_ready    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    item_next  = q_item;
                    pass_next  = 1'b0;
                    deg_next   = q_item.dzero;
                    row_next   = 2'd0;
                    nv_next[0] = 34'(q_item.dx);
                    nv_next[1] = 34'(q_item.dy);
                    nv_next[2] = 34'(q_item.dz);
                    m_next[0]  = mag34(34'(q_item.dx));
                    m_next[1]  = mag34(34'(q_item.dy));
                    m_next[2]  = mag34(34'(q_item.dz));
                    state_next = q_item.dzero ? S_OUT : S_SCALE;
                end
            end

            S_SCALE:
            begin
                if (big == '0)
                begin
                    deg_next   = 1'b1;
                    row_next   = 2'd0;
                    state_next = S_OUT;
                end
                else if (big < (34'(1) << 30))
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        m_next[i] = m_reg[i] << 1;
                    end
                end
                else if (big >= (34'(1) << 31))
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        m_next[i] = m_reg[i] >> 1;
                    end
                end
                else
                begin
                    term_next  = '0;
                    ph_next    = 1'b0;
                    acc_next   = '0;
                    state_next = S_MAC;
                end
            end

            S_MAC:
            begin
                if (!ph_reg)
                begin
                    prod_next = op_a * op_b;
                    ph_next   = 1'b1;
                end
                else
                begin
                    ph_next   = 1'b0;
                    term_next = term_reg + 1'b1;
                    acc_next  = op_fin ? '0 : acc_sum;
                    if (term_reg == T_SQ_END)
                    begin
                        sx_next    = acc_sum[63:0];
                        sr_next    = '0;
                        sb_next    = 64'(1) << 62;
                        cnt_next   = '0;
                        state_next = S_SQRT;
                    end
                    if (term_reg == T_Y0) y_next[0] = yv;
                    if (term_reg == T_Y1) y_next[1] = yv;
                    if (term_reg == T_Y2) y_next[2] = yv;
                    if (term_reg == T_D0) t_next[0] = tv;
                    if (term_reg == T_D1) t_next[1] = tv;
                    if (term_reg == T_D2)
                    begin
                        t_next[2]  = tv;
                        row_next   = 2'd0;
                        state_next = S_OUT;
                    end
                end
            end

            S_SQRT:
            begin
                if (sx_reg >= rb)
                begin
                    sx_next = sx_reg - rb;
                    sr_next = (sr_reg >> 1) + sb_reg;
                end
                else
                begin
                    sr_next = sr_reg >> 1;
                end
                sb_next  = sb_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(31))
                begin
                    len_next   = sr_next[32:0];
                    cnt_next   = '0;
                    comp_next  = 2'd0;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    rem_next = 34'(dvd[NW-1:QW]);
                    lo_next  = dvd[QW-1:0];
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    rem_next = ge ? 34'(trial - 35'(dvs)) : trial[33:0];
                    lo_next  = {lo_reg[QW-2:0], ge};
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CW'(QW))
                    begin
                        cnt_next  = '0;
                        comp_next = comp_reg + 1'b1;
                        if (!pass_reg)
                        begin
                            z_next[comp_reg] = uv;
                        end
                        else
                        begin
                            x_next[comp_reg] = uv;
                        end
                        if (comp_reg == 2'd2)
                        begin
                            if (!pass_reg)
                            begin
                                // x axis source: (z.z, 0, -z.x)
                                pass_next  = 1'b1;
                                nv_next[0] = 34'(uv);
                                nv_next[1] = '0;
                                nv_next[2] = -34'(z_reg[0]);
                                m_next[0]  = mag34(34'(uv));
                                m_next[1]  = '0;
                                m_next[2]  = mag34(-34'(z_reg[0]));
                                state_next = S_SCALE;
                            end
                            else
                            begin
                                term_next  = T_Y_FIRST;
                                ph_next    = 1'b0;
                                acc_next   = '0;
                                state_next = S_MAC;
                            end
                        end
                    end
                end
            end

            S_OUT:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next  = 1'b1;
                    od_next  = {c3, c2, c1, c0};
                    ou_next  = {deg_reg, row_reg};
                    ol_next  = row_reg == 2'd3;
                    row_next = row_reg + 1'b1;
                    if (row_reg == 2'd3)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        pass_reg <= pass_next;
        deg_reg  <= deg_next;
        nv_reg   <= nv_next;
        m_reg    <= m_next;
        z_reg    <= z_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        t_reg    <= t_next;
        sx_reg   <= sx_next;
        sr_reg   <= sr_next;
        sb_reg   <= sb_next;
        len_reg  <= len_next;
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        cnt_reg  <= cnt_next;
        comp_reg <= comp_next;
        row_reg  <= row_next;
        term_reg <= term_next;
        ph_reg   <= ph_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        od_reg   <= od_next;
        ou_reg   <= ou_next;
        ol_reg   <= ol_next;
    end

endmodule

`default_nettype wire

FILE: hdl/look_at_view_matrix.sv
`timescale 1ns / 1ps
`default_nettype none

// Left-handed look-at view matrix, up fixed at (0,1,0), Q15.16 in, Q17.16 out
// (fraction width set by FRAC_BITS). Each transfer in gives four row transfers
// out, row 3 flagged by tlast. The back end takes an item from the queue,
// then runs two normalisations. Each normalisation takes up to 30 one-bit
// scaling steps, a sum of squares, a 32-step bit-serial square root and
// three restoring divisions. After them the y axis and translations are
// summed on one shared 33x33 multiply-accumulate, and four row transfers
// follow. Eye on target goes straight to the four row transfers; a straight
// up or down view ends after the first normalisation. The input register and
// a two-entry queue take up to three further items while one is being
// worked on. When an axis has zero length all entries are zero and tuser bit
// 2 is set on all four rows.
module look_at_view_matrix #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // pos_x, pos_y, pos_z, target_x, target_y, target_z
    input  wire logic [lav_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // col0, col1, col2, col3
    output logic [lav_pkg::M_TDATA_W-1:0]      m_tdata,
    // row, degenerate
    output logic [lav_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                               m_tlast
);
    import lav_pkg::*;

    logic      f_valid, f_ready, b_valid, b_ready;
    lav_item_t f_item, b_item;

    lav_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .f_valid  (f_valid),
        .f_ready  (f_ready),
        .f_item   (f_item)
    );

    lav_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_item  (b_item)
    );

    lav_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (b_valid),
        .q_ready  (b_ready),
        .q_item   (b_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: hdl/lav_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lav_checker #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [lav_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [lav_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [lav_pkg::M_TUSER_W-1:0] m_tuser,
    input wire logic                          m_tlast
);
    import lav_pkg::*;

    logic [COL_W-1:0] col3;
    assign col3 = m_tdata[M_TDATA_W-1 -: COL_W];

    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser[1:0] == 2'd3)))
        else $error("tlast not on row 3");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2]) |-> (m_tdata == '0))
        else $error("degenerate row not zero");

    a_const_col: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[2] && m_tuser[1:0] != 2'd3) |-> (col3 == '0))
        else $error("constant column not zero");

    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[2] && m_tlast) |-> (col3 == (COL_W'(1) << FRAC_BITS)))
        else $error("row 3 constant not one");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled output changed");

endmodule

bind look_at_view_matrix lav_checker #(.FRAC_BITS(FRAC_BITS)) u_lav_checker (.*);

`default_nettype wire
